/* rtl/wsp_pkg.sv */
package wsp_pkg;

  // Projection constants
  localparam int SCREEN_WIDTH = 128;
  localparam int NEAR_DIST    = 64;
  localparam int CLIP_DEPTH   = 32;
  localparam int WALL_SCALE   = 128;
  localparam int TEX_SPAN     = 16;
  localparam int WALL_K       = WALL_SCALE * NEAR_DIST;

  // Divider: two quotient bits per stage, plus a sign fix-up stage
  localparam int DIV_STEPS = 16;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_VIEWER_X = 2'd0,
    CFG_VIEWER_Y = 2'd1,
    CFG_VIEW_COS = 2'd2,
    CFG_VIEW_SIN = 2'd3
  } cfg_idx_t;

  // Which endpoint is moved to the clip depth
  typedef enum logic [1:0] {
    CLIP_NONE,
    CLIP_START,
    CLIP_END
  } clip_sel_t;

  typedef struct packed {
    logic signed [15:0] start_wx;
    logic signed [15:0] start_wy;
    logic signed [15:0] end_wx;
    logic signed [15:0] end_wy;
  } seg_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] start_column;
    logic signed [15:0] start_height;
    logic signed [15:0] start_tex;
    logic signed [15:0] end_column;
    logic signed [15:0] end_height;
    logic signed [15:0] end_tex;
  } seg_out_t;

  // Divide request: sign of the numerator, its magnitude, positive divisor
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic [15:0] den;
  } div_req_t;

endpackage

/* rtl/wsp_div.sv */
// Pipelined restoring divider, truncates toward zero.
module wsp_div import wsp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  div_req_t           req,
  output logic signed [32:0] quo
);

  logic [15:0]        rem_r [1:DIV_STEPS-1];
  logic [15:0]        den_r [1:DIV_STEPS-1];
  logic [31:0]        nq_r  [1:DIV_STEPS];
  logic               neg_r [1:DIV_STEPS];
  logic signed [32:0] quo_r;

  // One restoring step: shift in a numerator bit, subtract if it fits
  function automatic logic [47:0] div_step(input logic [15:0] rem, input logic [31:0] nq,
                                           input logic [15:0] den);
    logic [16:0] t;
    logic [31:0] q;
    t = {rem, nq[31]};
    q = {nq[30:0], 1'b0};
    if (t >= {1'b0, den}) begin
      t    = t - {1'b0, den};
      q[0] = 1'b1;
    end
    return {t[15:0], q};
  endfunction

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [15:0] rem_in;
    logic [15:0] den_in;
    logic [31:0] nq_in;
    logic        neg_in;
    logic [47:0] r1;
    logic [47:0] r2;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = req.den;
      assign nq_in  = req.mag;
      assign neg_in = req.neg;
    end else begin : g_rest
      assign rem_in = rem_r[s];
      assign den_in = den_r[s];
      assign nq_in  = nq_r[s];
      assign neg_in = neg_r[s];
    end

    assign r1 = div_step(rem_in, nq_in, den_in);
    assign r2 = div_step(r1[47:32], r1[31:0], den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[s+1]  <= r2[31:0];
        neg_r[s+1] <= neg_in;
      end
    end

    // remainder and divisor are not needed past the last step
    if (s < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= r2[47:32];
          den_r[s+1] <= den_in;
        end
      end
    end
  end

  // Apply the sign
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[DIV_STEPS] ? -$signed({1'b0, nq_r[DIV_STEPS]})
                                :  $signed({1'b0, nq_r[DIV_STEPS]});
    end
  end

  assign quo = quo_r;

endmodule

/* rtl/wall_segment_projector_top.sv */
// Channel   Direction  Payload     Handshake
// in_       input      seg_in_t    in_valid / in_ready
// out_      output     seg_out_t   out_valid / out_ready
// cfg_      input      16-bit reg  cfg_we, cfg_index (no wait)
//
// One segment per cycle unless the output queue is full. Results pass two
// divider pipelines in turn (clip, then projection).
// rst_n is synchronous: valid bits, the output queue and the configuration registers reset.
// A 2-entry output queue takes results while out_ready is low; the whole
// pipeline holds only when that queue is full.
module wall_segment_projector_top import wsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  seg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output seg_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic signed [15:0] CLIP_S = 16'(CLIP_DEPTH);
  localparam logic signed [15:0] SW_S   = 16'(SCREEN_WIDTH);

  typedef struct packed {
    logic               hide;
    clip_sel_t          sel;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
  } clip_ctx_t;

  // Configuration registers
  logic signed [15:0] viewer_x_r, viewer_y_r;
  logic signed [9:0]  view_cos_r, view_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viewer_x_r <= '0;
      viewer_y_r <= '0;
      view_cos_r <= 10'sd256;
      view_sin_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIEWER_X: viewer_x_r <= cfg_data;
        CFG_VIEWER_Y: viewer_y_r <= cfg_data;
        CFG_VIEW_COS: view_cos_r <= cfg_data[9:0];
        CFG_VIEW_SIN: view_sin_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: holds only when the output queue is full
  logic [1:0] fifo_cnt_r;
  logic       pipe_en;
  assign pipe_en  = (fifo_cnt_r != 2'd2);
  assign in_ready = pipe_en;

  // Stage 1: translate
  logic               v1_r;
  logic signed [16:0] dx0_r, dy0_r, dx1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (pipe_en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx0_r <= 17'(in_data.start_wx) - 17'(viewer_x_r);
      dy0_r <= 17'(in_data.start_wy) - 17'(viewer_y_r);
      dx1_r <= 17'(in_data.end_wx) - 17'(viewer_x_r);
      dy1_r <= 17'(in_data.end_wy) - 17'(viewer_y_r);
    end
  end

  // Stage 2: rotation products
  logic               v2_r;
  logic signed [26:0] pcx0_r, psy0_r, psx0_r, pcy0_r;
  logic signed [26:0] pcx1_r, psy1_r, psx1_r, pcy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (pipe_en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pcx0_r <= 27'(view_cos_r) * 27'(dx0_r);
      psy0_r <= 27'(view_sin_r) * 27'(dy0_r);
      psx0_r <= 27'(view_sin_r) * 27'(dx0_r);
      pcy0_r <= 27'(view_cos_r) * 27'(dy0_r);
      pcx1_r <= 27'(view_cos_r) * 27'(dx1_r);
      psy1_r <= 27'(view_sin_r) * 27'(dy1_r);
      psx1_r <= 27'(view_sin_r) * 27'(dx1_r);
      pcy1_r <= 27'(view_cos_r) * 27'(dy1_r);
    end
  end

  // Stage 3: sums, keep bits 23:8
  logic               v3_r;
  logic signed [15:0] ax3_r, ay3_r, bx3_r, by3_r;
  logic signed [27:0] sax, say, sbx, sby;

  assign sax = 28'(pcx0_r) - 28'(psy0_r);
  assign say = 28'(psx0_r) + 28'(pcy0_r);
  assign sbx = 28'(pcx1_r) - 28'(psy1_r);
  assign sby = 28'(psx1_r) + 28'(pcy1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (pipe_en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ax3_r <= sax[23:8];
      ay3_r <= say[23:8];
      bx3_r <= sbx[23:8];
      by3_r <= sby[23:8];
    end
  end

  // Stage 4: cone and depth culling, pick the near endpoint
  logic               a_near, b_near, cone_end, cone_start, hide_cull;
  logic signed [17:0] m2by, two_ay;
  logic signed [15:0] xn, yn, xf, yf;
  logic signed [16:0] dn_w, den_w, dxd_w;
  clip_sel_t          sel_w;

  assign m2by       = -(18'(by3_r) <<< 1);
  assign two_ay     = 18'(ay3_r) <<< 1;
  assign cone_end   = (bx3_r < 0) && (m2by > 18'(bx3_r));
  assign cone_start = (ax3_r > 0) && (two_ay < 18'(ax3_r));
  assign a_near     = (ay3_r < CLIP_S);
  assign b_near     = (by3_r < CLIP_S);
  assign hide_cull  = cone_end || cone_start || (a_near && b_near);
  assign sel_w      = a_near ? CLIP_START : (b_near ? CLIP_END : CLIP_NONE);
  assign xn         = a_near ? ax3_r : bx3_r;
  assign yn         = a_near ? ay3_r : by3_r;
  assign xf         = a_near ? bx3_r : ax3_r;
  assign yf         = a_near ? by3_r : ay3_r;
  assign dn_w       = 17'(CLIP_S) - 17'(yn);
  assign den_w      = 17'(yf) - 17'(yn);
  assign dxd_w      = 17'(xf) - 17'(xn);

  logic        v4_r;
  clip_ctx_t   ctx4_r;
  logic [16:0] dn4_r, dxm4_r;
  logic [15:0] den4_r;
  logic        dxs4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (pipe_en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctx4_r <= '{hide: hide_cull, sel: sel_w, ax: ax3_r, ay: ay3_r, bx: bx3_r, by: by3_r};
      dn4_r  <= dn_w;
      den4_r <= den_w[15:0];
      dxs4_r <= dxd_w[16];
      dxm4_r <= dxd_w[16] ? 17'(-dxd_w) : 17'(dxd_w);
    end
  end

  // Stage 5: clip numerators (the product stays below 2^32 when an endpoint is clipped)
  logic        v5_r;
  clip_ctx_t   ctx5_r;
  div_req_t    reqx5_r, requ5_r;
  logic [31:0] numx_w;
  logic [31:0] numu_w;

  assign numx_w = 32'(dn4_r) * 32'(dxm4_r);
  assign numu_w = 32'(dn4_r) * 32'(TEX_SPAN);

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (pipe_en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctx5_r  <= ctx4_r;
      reqx5_r <= '{neg: dxs4_r, mag: numx_w, den: den4_r};
      requ5_r <= '{neg: 1'b0, mag: numu_w, den: den4_r};
    end
  end

  // Clip dividers and matching delay line
  logic signed [32:0] qx, qu;

  wsp_div u_div_clip_x (.clk(clk), .en(pipe_en), .req(reqx5_r), .quo(qx));
  wsp_div u_div_clip_u (.clk(clk), .en(pipe_en), .req(requ5_r), .quo(qu));

  logic      vl1_r   [0:DIV_LAT-1];
  clip_ctx_t ctxl1_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vl1_r[i] <= 1'b0;
    end else if (pipe_en) begin
      vl1_r[0] <= v5_r;
      for (int i = 1; i < DIV_LAT; i++) vl1_r[i] <= vl1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctxl1_r[0] <= ctx5_r;
      for (int i = 1; i < DIV_LAT; i++) ctxl1_r[i] <= ctxl1_r[i-1];
    end
  end

  // Stage 23: move the near endpoint to the clip depth
  clip_ctx_t          cc;
  logic signed [16:0] xclip_w;
  logic signed [15:0] x0_w, y0_w, x1_w, y1_w;
  logic [8:0]         u0_w, u1_w;

  assign cc      = ctxl1_r[DIV_LAT-1];
  assign xclip_w = 17'((cc.sel == CLIP_START) ? cc.ax : cc.bx) + $signed(qx[16:0]);

  always_comb begin
    x0_w = cc.ax;
    y0_w = cc.ay;
    x1_w = cc.bx;
    y1_w = cc.by;
    u0_w = '0;
    u1_w = 9'(TEX_SPAN);
    case (cc.sel)
      CLIP_START: begin
        x0_w = xclip_w[15:0];
        y0_w = CLIP_S;
        u0_w = qu[8:0];
      end
      CLIP_END: begin
        x1_w = xclip_w[15:0];
        y1_w = CLIP_S;
        u1_w = 9'(TEX_SPAN) - qu[8:0];
      end
      default: ;
    endcase
  end

  logic               v23_r, hide23_r;
  logic signed [15:0] x0_r, y0_r, x1_r, y1_r;
  logic [8:0]         u0_r, u1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v23_r <= 1'b0;
    else if (pipe_en) v23_r <= vl1_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hide23_r <= cc.hide;
      x0_r     <= x0_w;
      y0_r     <= y0_w;
      x1_r     <= x1_w;
      y1_r     <= y1_w;
      u0_r     <= u0_w;
      u1_r     <= u1_w;
    end
  end

  // Stage 24: projection numerators
  logic [16:0] x0m, x1m;
  assign x0m = x0_r[15] ? 17'(-17'(x0_r)) : 17'(x0_r);
  assign x1m = x1_r[15] ? 17'(-17'(x1_r)) : 17'(x1_r);

  logic     v24_r, hide24_r;
  div_req_t rca_r, rha_r, rta_r, rcb_r, rhb_r, rtb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v24_r <= 1'b0;
    else if (pipe_en) v24_r <= v23_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hide24_r <= hide23_r;
      rca_r <= '{neg: x0_r[15], mag: 32'(x0m) * 32'(NEAR_DIST), den: y0_r};
      rha_r <= '{neg: 1'b0, mag: 32'(WALL_K), den: y0_r};
      rta_r <= '{neg: 1'b0, mag: 32'(u0_r) * 32'(WALL_K), den: y0_r};
      rcb_r <= '{neg: x1_r[15], mag: 32'(x1m) * 32'(NEAR_DIST), den: y1_r};
      rhb_r <= '{neg: 1'b0, mag: 32'(WALL_K), den: y1_r};
      rtb_r <= '{neg: 1'b0, mag: 32'(u1_r) * 32'(WALL_K), den: y1_r};
    end
  end

  // Projection dividers
  logic signed [32:0] qca, qha, qta, qcb, qhb, qtb;

  wsp_div u_div_col_a (.clk(clk), .en(pipe_en), .req(rca_r), .quo(qca));
  wsp_div u_div_hgt_a (.clk(clk), .en(pipe_en), .req(rha_r), .quo(qha));
  wsp_div u_div_tex_a (.clk(clk), .en(pipe_en), .req(rta_r), .quo(qta));
  wsp_div u_div_col_b (.clk(clk), .en(pipe_en), .req(rcb_r), .quo(qcb));
  wsp_div u_div_hgt_b (.clk(clk), .en(pipe_en), .req(rhb_r), .quo(qhb));
  wsp_div u_div_tex_b (.clk(clk), .en(pipe_en), .req(rtb_r), .quo(qtb));

  logic vl2_r [0:DIV_LAT-1];
  logic hl2_r [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vl2_r[i] <= 1'b0;
    end else if (pipe_en) begin
      vl2_r[0] <= v24_r;
      for (int i = 1; i < DIV_LAT; i++) vl2_r[i] <= vl2_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hl2_r[0] <= hide24_r;
      for (int i = 1; i < DIV_LAT; i++) hl2_r[i] <= hl2_r[i-1];
    end
  end

  // Columns and screen test
  logic signed [32:0] ca_w, cb_w;
  logic signed [15:0] ca, cb;
  logic               off_screen, vis;
  seg_out_t           res;

  assign ca_w       = qca + 33'(SCREEN_WIDTH / 2);
  assign cb_w       = qcb + 33'(SCREEN_WIDTH / 2);
  assign ca         = ca_w[15:0];
  assign cb         = cb_w[15:0];
  assign off_screen = (ca >= cb) || (cb < 0) || (ca >= SW_S);
  assign vis        = !hl2_r[DIV_LAT-1] && !off_screen;

  always_comb begin
    res.visible      = vis;
    res.start_column = vis ? ca : '0;
    res.start_height = vis ? qha[15:0] : '0;
    res.start_tex    = vis ? qta[15:0] : '0;
    res.end_column   = vis ? cb : '0;
    res.end_height   = vis ? qhb[15:0] : '0;
    res.end_tex      = vis ? qtb[15:0] : '0;
  end

  // Output queue, two entries
  seg_out_t fifo_r [0:1];
  logic     wr_ptr_r, rd_ptr_r;
  logic     push, pop;

  assign push      = pipe_en && vl2_r[DIV_LAT-1];
  assign out_valid = (fifo_cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_cnt_r <= 2'd0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + 2'd1;
        2'b01:   fifo_cnt_r <= fifo_cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= res;
  end

  // Checks
  a_fifo_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |-> out_data.start_column < out_data.end_column)
    else $error("visible segment with columns out of order");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |->
      out_data.start_column == 16'sd0 && out_data.start_height == 16'sd0 &&
      out_data.start_tex == 16'sd0 && out_data.end_column == 16'sd0 &&
      out_data.end_height == 16'sd0 && out_data.end_tex == 16'sd0)
    else $error("hidden segment with nonzero fields");

endmodule
